/* rtl/core/tdh_pkg.sv */
// tdh_pkg: types, codes and derived constants of the trigger delay histogrammer
// used by every module of the core and by its checker; depends on nothing
`default_nettype none

package tdh_pkg;

   localparam int BIN_COUNT   = 4200;
   localparam int BIN_TICKS   = 10000;

   localparam int MODE_W      = 3;
   localparam int TIME_W      = 64;
   localparam int FIELD_BIN_W = 13;
   localparam int CNT_W       = 32;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   localparam logic [MODE_W-1:0] MODE_TRIG     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_HIT_ONE  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_HIT_TWO  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_READ_ONE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_READ_TWO = 3'd4;

   localparam int ADDR_W = $clog2(BIN_COUNT);

   // delays at or above this limit land in the overflow counter
   localparam logic [TIME_W-1:0] DELAY_LIMIT = 64'(BIN_COUNT) * 64'(BIN_TICKS);
   localparam int DELAY_W  = $clog2(DELAY_LIMIT);

   // reciprocal divide: quotient estimate is exact or one low
   localparam int TICK_LOG = $clog2(BIN_TICKS + 1) - 1;
   localparam int TICK_W   = $clog2(BIN_TICKS + 1);
   localparam int RECIP_W  = DELAY_W - TICK_LOG + 1;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'((65'(1) << DELAY_W) / 65'(BIN_TICKS));
   localparam int PROD_W   = DELAY_W + RECIP_W;
   localparam int REM_W    = RECIP_W + TICK_W;

   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [MODE_W-1:0]      mode;
      logic [TIME_W-1:0]      event_time;
      logic [FIELD_BIN_W-1:0] read_bin;
   } tdh_req_type;

   typedef struct packed {
      logic [CNT_W-1:0]       bin_count;
      logic                   hit_binned;
      logic [FIELD_BIN_W-1:0] bin_hit;
   } tdh_rsp_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_HIT,
      OP_READ
   } tdh_op_type;

   typedef struct packed {
      tdh_op_type             op;
      logic                   det;
      logic                   ovf;
      logic [ADDR_W-1:0]      addr;
      logic [FIELD_BIN_W-1:0] bin_hit;
   } tdh_entry_type;

   typedef struct packed {
      logic clearing;
      logic pop;
   } tdh_back_status_type;

endpackage

`default_nettype wire

/* rtl/core/trigger_delay_histogrammer_core.sv */
// trigger_delay_histogrammer_core: top level of the delay histogrammer
// instantiates tdh_front, tdh_queue and tdh_back; depends on tdh_pkg
//
// Takes one item per clock while req_stall is low and returns one result per
// item. The front keeps the trigger time, forms the delay and divides it by the
// bin width in three pipeline stages; an eight-entry queue, which also covers
// items still in those stages, feeds the back part, whose read-modify-write of
// the histogram memories forwards between neighboring items. After reset the
// block clears both 4200-entry histograms, one entry per cycle, and holds
// req_stall high while it clears them.
`default_nettype none

module trigger_delay_histogrammer_core import tdh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  tdh_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output tdh_rsp_type rsp_data
);

   tdh_back_status_type back_status;
   logic                push_valid;
   tdh_entry_type       push_entry;
   logic                head_valid;
   tdh_entry_type       head_entry;

   tdh_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .back_status (back_status),
      .push_valid  (push_valid),
      .push_entry  (push_entry)
   );

   tdh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_entry (push_entry),
      .pop        (back_status.pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   tdh_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .status     (back_status),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

/* rtl/core/tdh_front.sv */
// tdh_front: accepts items, keeps the trigger time, classifies each item and
// computes the delay bin in three stages; depends on tdh_pkg
`default_nettype none

module tdh_front import tdh_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  tdh_req_type         req_data,
   input  tdh_back_status_type back_status,
   output logic                push_valid,
   output tdh_entry_type       push_entry
);

   typedef struct packed {
      tdh_op_type        op;
      logic              det;
      logic              ovf;
      logic [ADDR_W-1:0] addr;
      logic [TIME_W-1:0] delay;
   } s1_type;

   typedef struct packed {
      tdh_op_type         op;
      logic               det;
      logic               ovf;
      logic [ADDR_W-1:0]  addr;
      logic [DELAY_W-1:0] low_delay;
      logic [PROD_W-1:0]  prod;
   } s2_type;

   typedef struct packed {
      tdh_op_type         op;
      logic               det;
      logic               ovf;
      logic [ADDR_W-1:0]  addr;
      logic [DELAY_W-1:0] low_delay;
      logic [RECIP_W-1:0] quot;
      logic [REM_W-1:0]   qprod;
   } s3_type;

   logic              accept;
   logic [TIME_W:0]   diff;
   logic              in_range;
   logic              at_ovf;

   logic [OCC_W-1:0]  occ_ff, occ_in;
   logic [TIME_W-1:0] trig_time_ff, trig_time_in;
   logic              trig_seen_ff, trig_seen_in;
   logic              s1_valid_ff, s2_valid_ff, s3_valid_ff;
   s1_type            s1_ff, s1_in;
   s2_type            s2_ff, s2_in;
   s3_type            s3_ff, s3_in;

   logic [REM_W-1:0]  rem;
   logic              bump;
   logic [ADDR_W-1:0] bin;

   assign req_stall = back_status.clearing || (occ_ff == OCC_W'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   // occupancy counts items in the stages plus the queue
   assign occ_in = occ_ff + OCC_W'(accept) - OCC_W'(back_status.pop);

   assign diff     = {1'b0, req_data.event_time} - {1'b0, trig_time_ff};
   assign in_range = 32'(req_data.read_bin) < 32'(BIN_COUNT);
   assign at_ovf   = 32'(req_data.read_bin) == 32'(BIN_COUNT);

   always_comb begin
      trig_time_in = trig_time_ff;
      trig_seen_in = trig_seen_ff;
      if (accept && req_data.mode == MODE_TRIG) begin
         trig_time_in = req_data.event_time;
         trig_seen_in = 1'b1;
      end
   end

   always_comb begin
      s1_in       = '0;
      s1_in.op    = OP_NONE;
      s1_in.delay = diff[TIME_W-1:0];
      case (req_data.mode)
         MODE_TRIG: begin
            s1_in.op = OP_NONE;
         end
         MODE_HIT_ONE, MODE_HIT_TWO: begin
            s1_in.op  = (trig_seen_ff && !diff[TIME_W]) ? OP_HIT : OP_NONE;
            s1_in.det = (req_data.mode == MODE_HIT_TWO);
         end
         MODE_READ_ONE, MODE_READ_TWO: begin
            s1_in.op   = (in_range || at_ovf) ? OP_READ : OP_NONE;
            s1_in.det  = (req_data.mode == MODE_READ_TWO);
            s1_in.ovf  = at_ovf;
            s1_in.addr = ADDR_W'(32'(req_data.read_bin));
         end
         default: begin
            s1_in.op = OP_NONE;
         end
      endcase
   end

   always_comb begin
      s2_in.op        = s1_ff.op;
      s2_in.det       = s1_ff.det;
      s2_in.addr      = s1_ff.addr;
      s2_in.ovf       = (s1_ff.op == OP_HIT) ? (s1_ff.delay >= DELAY_LIMIT) : s1_ff.ovf;
      s2_in.low_delay = s1_ff.delay[DELAY_W-1:0];
      s2_in.prod      = PROD_W'(s1_ff.delay[DELAY_W-1:0]) * PROD_W'(RECIP);
   end

   always_comb begin
      s3_in.op        = s2_ff.op;
      s3_in.det       = s2_ff.det;
      s3_in.ovf       = s2_ff.ovf;
      s3_in.addr      = s2_ff.addr;
      s3_in.low_delay = s2_ff.low_delay;
      s3_in.quot      = s2_ff.prod[PROD_W-1 -: RECIP_W];
      s3_in.qprod     = REM_W'(s2_ff.prod[PROD_W-1 -: RECIP_W]) * REM_W'(BIN_TICKS);
   end

   // quotient correction
   assign rem  = REM_W'(s3_ff.low_delay) - s3_ff.qprod;
   assign bump = rem >= REM_W'(BIN_TICKS);
   assign bin  = ADDR_W'(s3_ff.quot) + ADDR_W'(bump);

   always_comb begin
      push_entry.op      = s3_ff.op;
      push_entry.det     = s3_ff.det;
      push_entry.ovf     = s3_ff.ovf;
      push_entry.addr    = s3_ff.addr;
      push_entry.bin_hit = '0;
      if (s3_ff.op == OP_HIT) begin
         if (s3_ff.ovf) begin
            push_entry.bin_hit = FIELD_BIN_W'(BIN_COUNT);
         end else begin
            push_entry.addr    = bin;
            push_entry.bin_hit = FIELD_BIN_W'(bin);
         end
      end
   end

   assign push_valid = s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         trig_time_ff <= '0;
         trig_seen_ff <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         trig_time_ff <= trig_time_in;
         trig_seen_ff <= trig_seen_in;
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      s3_ff <= s3_in;
   end

endmodule

`default_nettype wire

/* rtl/core/tdh_queue.sv */
// tdh_queue: small fifo of classified items between the front and back parts
// depends on tdh_pkg
`default_nettype none

module tdh_queue import tdh_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  tdh_entry_type push_entry,
   input  logic          pop,
   output logic          head_valid,
   output tdh_entry_type head_entry
);

   tdh_entry_type     slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OCC_W-1:0]  count_ff, count_in;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] ptr);
      logic [QPTR_W-1:0] nxt;
      nxt = (ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
      return nxt;
   endfunction

   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
   assign rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
   assign count_in  = count_ff + OCC_W'(push) - OCC_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/tdh_back.sv */
// tdh_back: histogram memories, overflow counters, read-modify-write with
// forwarding, clearing pass after reset and the result register; depends on tdh_pkg
`default_nettype none

module tdh_back import tdh_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  tdh_entry_type       head_entry,
   output tdh_back_status_type status,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output tdh_rsp_type         rsp_data
);

   logic [CNT_W-1:0]  mem_one [BIN_COUNT];
   logic [CNT_W-1:0]  mem_two [BIN_COUNT];

   logic              advance;
   logic              pop;
   logic              fwd;
   logic [CNT_W-1:0]  mem_val;
   logic [CNT_W-1:0]  cur;
   logic [CNT_W-1:0]  bumped;
   logic              is_hit;
   logic              wr_mem;

   logic              clr_busy_ff, clr_busy_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic              b1_valid_ff, b1_valid_in;
   tdh_entry_type     b1_ff;
   logic [CNT_W-1:0]  rd_one_ff, rd_two_ff;
   logic [CNT_W-1:0]  ovf_one_ff, ovf_one_in;
   logic [CNT_W-1:0]  ovf_two_ff, ovf_two_in;
   logic              lw_valid_ff, lw_valid_in;
   logic              lw_det_ff;
   logic [ADDR_W-1:0] lw_addr_ff;
   logic [CNT_W-1:0]  lw_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   tdh_rsp_type       rsp_ff, rsp_in;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign pop     = advance && head_valid && !clr_busy_ff;

   assign status.clearing = clr_busy_ff;
   assign status.pop      = pop;

   // clearing pass
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(BIN_COUNT - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   // last write is forwarded to the item that read behind it
   assign fwd     = lw_valid_ff && (lw_det_ff == b1_ff.det) && (lw_addr_ff == b1_ff.addr);
   assign mem_val = fwd ? lw_data_ff : (b1_ff.det ? rd_two_ff : rd_one_ff);
   assign cur     = b1_ff.ovf ? (b1_ff.det ? ovf_two_ff : ovf_one_ff) : mem_val;
   assign bumped  = (cur == CNT_MAX) ? cur : cur + 1'b1;

   assign is_hit = advance && b1_valid_ff && (b1_ff.op == OP_HIT);
   assign wr_mem = is_hit && !b1_ff.ovf;

   assign ovf_one_in = (is_hit && b1_ff.ovf && !b1_ff.det) ? bumped : ovf_one_ff;
   assign ovf_two_in = (is_hit && b1_ff.ovf &&  b1_ff.det) ? bumped : ovf_two_ff;

   assign b1_valid_in  = advance ? pop : b1_valid_ff;
   assign lw_valid_in  = advance ? wr_mem : lw_valid_ff;
   assign rsp_valid_in = advance ? b1_valid_ff : rsp_valid_ff;

   always_comb begin
      rsp_in = '0;
      case (b1_ff.op)
         OP_HIT: begin
            rsp_in.hit_binned = 1'b1;
            rsp_in.bin_hit    = b1_ff.bin_hit;
         end
         OP_READ: begin
            rsp_in.bin_count = cur;
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         b1_valid_ff  <= 1'b0;
         lw_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ovf_one_ff   <= '0;
         ovf_two_ff   <= '0;
      end else begin
         clr_busy_ff  <= clr_busy_in;
         clr_addr_ff  <= clr_addr_in;
         b1_valid_ff  <= b1_valid_in;
         lw_valid_ff  <= lw_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         ovf_one_ff   <= ovf_one_in;
         ovf_two_ff   <= ovf_two_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b1_ff      <= head_entry;
         lw_det_ff  <= b1_ff.det;
         lw_addr_ff <= b1_ff.addr;
         lw_data_ff <= bumped;
         rsp_ff     <= rsp_in;
      end
   end

   // histogram memories
   always_ff @(posedge clock) begin
      if (advance) begin
         rd_one_ff <= mem_one[head_entry.addr];
         rd_two_ff <= mem_two[head_entry.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem_one[clr_addr_ff] <= '0;
      end else if (wr_mem && !b1_ff.det) begin
         mem_one[b1_ff.addr] <= bumped;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem_two[clr_addr_ff] <= '0;
      end else if (wr_mem && b1_ff.det) begin
         mem_two[b1_ff.addr] <= bumped;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

/* rtl/core/tdh_checker.sv */
// tdh_checker: port-level assertions on the delay histogrammer core
// bound to trigger_delay_histogrammer_core; depends on tdh_pkg
`default_nettype none

module tdh_checker import tdh_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input tdh_rsp_type rsp_data
);

   // histograms are being cleared right after reset
   a_clear_after_reset: assert property (@(posedge clock) reset |=> req_stall)
      else $error("input not stalled after reset");

   a_idle_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_bin_when_binned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit_binned |-> rsp_data.bin_hit == '0)
      else $error("bin named without a binned hit");

   a_hit_no_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit_binned |-> rsp_data.bin_count == '0)
      else $error("binned hit carries a count");

endmodule

bind trigger_delay_histogrammer_core tdh_checker u_tdh_checker (.*);

`default_nettype wire
